>>> rtl/core/ctok_pkg.sv
// C source tokenizer: shared types, constants and the keyword table.
// No dependencies; every file of the block but ctok_if refers to it by scoped names.
`default_nettype none

package ctok_pkg;

   // Longest token length that is counted exactly; longer tokens saturate.
   localparam int TOKEN_MAX = 128;
   localparam logic [7:0] LEN_CAP = 8'((TOKEN_MAX > 255) ? 255 : TOKEN_MAX);
   localparam logic [23:0] LINE_TOP = 24'hFF_FFFF;

   // Token kinds
   localparam logic [2:0] KIND_KEYWORD  = 3'd0;
   localparam logic [2:0] KIND_IDENT    = 3'd1;
   localparam logic [2:0] KIND_STRING   = 3'd2;
   localparam logic [2:0] KIND_CONST    = 3'd3;
   localparam logic [2:0] KIND_OPERATOR = 3'd4;
   localparam logic [2:0] KIND_SEP      = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int CNT_W     = $clog2(RSP_DEPTH + 1);

   // Keyword table: text right-justified, first char in the highest used byte
   localparam int KW_COUNT = 32;
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("int"),      64'("float"),    64'("double"),   64'("long"),
      64'("while"),    64'("for"),      64'("auto"),     64'("struct"),
      64'("break"),    64'("else"),     64'("switch"),   64'("case"),
      64'("enum"),     64'("register"), 64'("typedef"),  64'("char"),
      64'("extern"),   64'("return"),   64'("union"),    64'("const"),
      64'("short"),    64'("unsigned"), 64'("continue"), 64'("signed"),
      64'("void"),     64'("default"),  64'("goto"),     64'("sizeof"),
      64'("do"),       64'("if"),       64'("static"),   64'("volatile")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd6, 4'd4, 4'd5, 4'd3, 4'd4, 4'd6,
      4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd8, 4'd7, 4'd4,
      4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd8, 4'd8, 4'd6,
      4'd4, 4'd7, 4'd4, 4'd6, 4'd2, 4'd2, 4'd6, 4'd8
   };

   // Character at position pos of keyword idx (only meaningful for pos < length)
   function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [2:0] pos);
      logic [2:0] byte_sel;
      byte_sel = 3'(KW_LEN[idx] - 4'd1 - {1'b0, pos});
      return KW_TEXT[idx][{byte_sel, 3'b000} +: 8];
   endfunction

   // One input beat as held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] text_byte;
      logic       end_of_text;
   } beat_type;

   // One result item
   typedef struct packed {
      logic [2:0]  token_kind;
      logic [4:0]  keyword_number;
      logic [7:0]  first_char;
      logic [7:0]  second_char;
      logic [31:0] start_offset;
      logic [7:0]  token_length;
      logic [23:0] line_number;
      logic        run_last;
   } rsp_item_type;

   // Results of one byte going into the queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

`default_nettype wire

>>> rtl/core/ctok_if.sv
// C source tokenizer: valid/ready channel interfaces for source bytes and tokens.
// No dependencies.
`default_nettype none

interface ctok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ctok_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [4:0]  keyword_number;
   logic [7:0]  first_char;
   logic [7:0]  second_char;
   logic [31:0] start_offset;
   logic [7:0]  token_length;
   logic [23:0] line_number;
   logic        run_last;

   modport source (output valid, token_kind, keyword_number, first_char, second_char,
                   start_offset, token_length, line_number, run_last, input ready);
   modport sink   (input valid, token_kind, keyword_number, first_char, second_char,
                   start_offset, token_length, line_number, run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/c_source_tokenizer.sv
// C source tokenizer, top level: input register, scanner, result queue.
// Depends on ctok_pkg, ctok_if, ctok_in_stage, ctok_scan, ctok_rsp_fifo.
//
//  channel  | dir | handshake        | beat
//  ---------+-----+------------------+-----------------------------------------
//  req_bus  | in  | valid/ready      | text_byte, end_of_text
//  rsp_bus  | out | valid/ready      | one token: kind, keyword, chars, offset,
//           |     |                  | length, line, run_last
//
// One source byte is accepted per cycle while the queue has room; its tokens pass the input register and the queue.
// A byte gives zero, one or two tokens; the 4-entry result queue drains one per cycle while rsp_bus is ready.
// req_bus stalls only when the queue cannot take two more tokens.
// Synchronous reset clears the scanner state and empties the queue; no clearing pass.
// end_of_text flushes the pending token and restarts offset and line count.
`default_nettype none

module c_source_tokenizer (
   input  logic       clock,
   input  logic       reset,
   ctok_req_if.sink   req_bus,
   ctok_rsp_if.source rsp_bus
);

   ctok_pkg::beat_type beat;
   ctok_pkg::push_type push;
   logic room;
   logic take;

   // Scanner consumes the held beat when the queue has room for two tokens
   assign take = beat.valid && room;

   ctok_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .beat    (beat)
   );

   ctok_scan u_scan (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .fire  (take),
      .push  (push)
   );

   ctok_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

>>> rtl/core/ctok_in_stage.sv
// C source tokenizer: input register for one byte beat.
// Depends on ctok_pkg and ctok_req_if.
`default_nettype none

module ctok_in_stage (
   input  logic              clock,
   input  logic              reset,
   ctok_req_if.sink          req_bus,
   input  logic              take,
   output ctok_pkg::beat_type beat
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic       stage_open;

   // Register is free when empty or when its beat moves on this cycle
   assign stage_open    = !valid_ff || take;
   assign req_bus.ready = stage_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_open) begin
         valid_ff <= req_bus.valid;
      end
      if (stage_open && req_bus.valid) begin
         byte_ff <= req_bus.text_byte;
         end_ff  <= req_bus.end_of_text;
      end
   end

   assign beat.valid       = valid_ff;
   assign beat.text_byte   = byte_ff;
   assign beat.end_of_text = end_ff;

endmodule

`default_nettype wire

>>> rtl/core/ctok_scan.sv
// C source tokenizer: scanner state and per-byte token logic (up to two tokens a byte).
// Depends on ctok_pkg.
`default_nettype none

module ctok_scan (
   input  logic               clock,
   input  logic               reset,
   input  ctok_pkg::beat_type beat,
   input  logic               fire,
   output ctok_pkg::push_type push
);

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_DIRECTIVE, MODE_SLASH, MODE_LINECOM, MODE_BLOCKCOM,
      MODE_IDENT, MODE_STRING, MODE_NUMBER, MODE_OP
   } mode_type;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   // State
   mode_type    mode_ff,   mode_in;
   logic [7:0]  held_ff,   held_in;
   logic [31:0] alive_ff,  alive_in;
   logic [7:0]  len_ff,    len_in;
   logic [31:0] origin_ff, origin_in;
   logic [23:0] line_ff,   line_in;
   logic [31:0] pos_ff,    pos_in;
   logic        star_ff,   star_in;

   // After the byte, before the end-of-text flush
   mode_type    mode_mid;
   logic [7:0]  held_mid;
   logic [31:0] alive_mid;
   logic [7:0]  len_mid;
   logic [31:0] origin_mid;
   logic [23:0] line_mid;
   logic        star_mid;

   logic [7:0] c;
   logic is_letter, is_digit, is_nl, is_blank, is_op, is_sep;
   logic fr_begin, fr_emit;
   mode_type fr_mode;
   logic fresh;

   logic a_valid, b_valid, c_valid;
   ctok_pkg::rsp_item_type a_item, b_item, c_item, slot0, slot1;
   logic [1:0] slot_count;

   function automatic logic [23:0] line_sat_inc(input logic [23:0] l);
      return (l < ctok_pkg::LINE_TOP) ? l + 24'd1 : l;
   endfunction

   function automatic logic [7:0] len_sat_inc(input logic [7:0] l);
      return (l < ctok_pkg::LEN_CAP) ? l + 8'd1 : l;
   endfunction

   // Keywords still matching after char ch at position p
   function automatic logic [31:0] kw_match(input logic [31:0] alive, input logic [7:0] p,
                                            input logic [7:0] ch);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < ctok_pkg::KW_COUNT; i++) begin
         m[i] = alive[i] && (p < {4'd0, ctok_pkg::KW_LEN[i]}) &&
                (ctok_pkg::kw_char(5'(i), p[2:0]) == ch);
      end
      return m;
   endfunction

   function automatic ctok_pkg::rsp_item_type make_item(
      input logic [2:0] kind, input logic [4:0] kw, input logic [7:0] c1,
      input logic [7:0] c2, input logic [31:0] origin, input logic [7:0] len,
      input logic [23:0] line);
      ctok_pkg::rsp_item_type r;
      r.token_kind     = kind;
      r.keyword_number = kw;
      r.first_char     = c1;
      r.second_char    = c2;
      r.start_offset   = origin;
      r.token_length   = len;
      r.line_number    = line;
      r.run_last       = 1'b0;
      return r;
   endfunction

   // Finished word: keyword when a still-alive keyword has exactly this length
   function automatic ctok_pkg::rsp_item_type flush_word(
      input logic [31:0] alive, input logic [7:0] len, input logic [7:0] held,
      input logic [31:0] origin, input logic [23:0] line);
      logic       hit;
      logic [4:0] idx;
      hit = 1'b0;
      idx = '0;
      for (int i = ctok_pkg::KW_COUNT - 1; i >= 0; i--) begin
         if (alive[i] && (len == {4'd0, ctok_pkg::KW_LEN[i]})) begin
            hit = 1'b1;
            idx = 5'(i);
         end
      end
      return hit ? make_item(ctok_pkg::KIND_KEYWORD, idx, held, 8'd0, origin, len, line)
                 : make_item(ctok_pkg::KIND_IDENT, 5'd0, held, 8'd0, origin, len, line);
   endfunction

   // Byte classes
   assign c         = beat.text_byte;
   assign is_letter = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDER);
   assign is_digit  = c inside {[8'h30:8'h39]};
   assign is_nl     = (c == CH_NL);
   assign is_blank  = c inside {CH_SPACE, CH_TAB};
   // - = + * % ! ? > <
   assign is_op     = c inside {8'h2D, 8'h3D, 8'h2B, 8'h2A, 8'h25, 8'h21, 8'h3F, 8'h3E, 8'h3C};
   // ( ) [ ] { } , ; :
   assign is_sep    = c inside {8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2C, 8'h3B, 8'h3A};

   // What the byte does when seen outside any token
   always_comb begin
      fr_mode = MODE_IDLE;
      if (c == CH_HASH)       fr_mode = MODE_DIRECTIVE;
      else if (c == CH_SLASH) fr_mode = MODE_SLASH;
      else if (is_letter)     fr_mode = MODE_IDENT;
      else if (c == CH_QUOTE) fr_mode = MODE_STRING;
      else if (is_digit)      fr_mode = MODE_NUMBER;
      else if (is_op)         fr_mode = MODE_OP;
      fr_begin = (c == CH_SLASH) || is_letter || (c == CH_QUOTE) || is_digit || is_op;
      fr_emit  = !(is_nl || is_blank || (c == CH_HASH) || fr_begin);
   end

   // Per-byte transition and token emission
   always_comb begin
      mode_mid   = mode_ff;
      held_mid   = held_ff;
      alive_mid  = alive_ff;
      len_mid    = len_ff;
      origin_mid = origin_ff;
      line_mid   = line_ff;
      star_mid   = star_ff;
      fresh      = 1'b0;
      a_valid    = 1'b0;
      a_item     = '0;
      b_valid    = 1'b0;
      b_item     = '0;
      c_valid    = 1'b0;
      c_item     = '0;

      case (mode_ff)
         MODE_DIRECTIVE, MODE_LINECOM: begin
            if (is_nl) begin
               line_mid = line_sat_inc(line_ff);
               mode_mid = MODE_IDLE;
            end
         end
         MODE_BLOCKCOM: begin
            if (is_nl) line_mid = line_sat_inc(line_ff);
            if (star_ff && (c == CH_SLASH)) begin
               mode_mid = MODE_IDLE;
               star_mid = 1'b0;
            end else begin
               star_mid = (c == CH_STAR);
            end
         end
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               mode_mid = MODE_LINECOM;
            end else if (c == CH_STAR) begin
               mode_mid = MODE_BLOCKCOM;
               star_mid = 1'b0;
            end else begin
               a_valid = 1'b1;
               a_item  = make_item(ctok_pkg::KIND_OPERATOR, 5'd0, CH_SLASH, 8'd0,
                                   origin_ff, 8'd1, line_ff);
               fresh   = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_letter || is_digit) begin
               alive_mid = kw_match(alive_ff, len_ff, c);
               len_mid   = len_sat_inc(len_ff);
            end else begin
               a_valid = 1'b1;
               a_item  = flush_word(alive_ff, len_ff, held_ff, origin_ff, line_ff);
               fresh   = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit || (c == CH_DOT)) begin
               len_mid = len_sat_inc(len_ff);
            end else begin
               a_valid = 1'b1;
               a_item  = make_item(ctok_pkg::KIND_CONST, 5'd0, held_ff, 8'd0,
                                   origin_ff, len_ff, line_ff);
               fresh   = 1'b1;
            end
         end
         MODE_STRING: begin
            len_mid = len_sat_inc(len_ff);
            if (c == CH_QUOTE) begin
               a_valid  = 1'b1;
               a_item   = make_item(ctok_pkg::KIND_STRING, 5'd0, held_ff, 8'd0,
                                    origin_ff, len_sat_inc(len_ff), line_ff);
               mode_mid = MODE_IDLE;
            end
         end
         MODE_OP: begin
            a_valid = 1'b1;
            if ((c == CH_EQ) && (held_ff inside {CH_EQ, CH_BANG, CH_GT, CH_LT})) begin
               a_item   = make_item(ctok_pkg::KIND_OPERATOR, 5'd0, held_ff, c,
                                    origin_ff, 8'd2, line_ff);
               mode_mid = MODE_IDLE;
            end else begin
               a_item = make_item(ctok_pkg::KIND_OPERATOR, 5'd0, held_ff, 8'd0,
                                  origin_ff, 8'd1, line_ff);
               fresh  = 1'b1;
            end
         end
         default: fresh = 1'b1;
      endcase

      // Byte handled as a new start (idle, or it ended the pending token)
      if (fresh) begin
         mode_mid = fr_mode;
         if (fr_begin) begin
            held_mid   = c;
            origin_mid = pos_ff;
            len_mid    = 8'd1;
         end
         if (is_letter) alive_mid = kw_match('1, 8'd0, c);
         if (is_nl) line_mid = line_sat_inc(line_ff);
         b_valid = fr_emit;
         b_item  = make_item(is_sep ? ctok_pkg::KIND_SEP : ctok_pkg::KIND_UNKNOWN, 5'd0,
                             c, 8'd0, pos_ff, 8'd1, line_ff);
      end

      // End of text: flush the pending token
      if (beat.end_of_text) begin
         case (mode_mid)
            MODE_IDENT: begin
               c_valid = 1'b1;
               c_item  = flush_word(alive_mid, len_mid, held_mid, origin_mid, line_mid);
            end
            MODE_NUMBER: begin
               c_valid = 1'b1;
               c_item  = make_item(ctok_pkg::KIND_CONST, 5'd0, held_mid, 8'd0,
                                   origin_mid, len_mid, line_mid);
            end
            MODE_STRING: begin
               c_valid = 1'b1;
               c_item  = make_item(ctok_pkg::KIND_UNKNOWN, 5'd0, held_mid, 8'd0,
                                   origin_mid, len_mid, line_mid);
            end
            MODE_OP: begin
               c_valid = 1'b1;
               c_item  = make_item(ctok_pkg::KIND_OPERATOR, 5'd0, held_mid, 8'd0,
                                   origin_mid, 8'd1, line_mid);
            end
            MODE_SLASH: begin
               c_valid = 1'b1;
               c_item  = make_item(ctok_pkg::KIND_OPERATOR, 5'd0, CH_SLASH, 8'd0,
                                   origin_mid, 8'd1, line_mid);
            end
            default: c_valid = 1'b0;
         endcase
      end
   end

   // Pack the tokens in order into two slots; mark the last one
   always_comb begin
      slot0      = '0;
      slot1      = '0;
      slot_count = 2'd0;
      if (a_valid) begin
         slot0 = a_item;
         if (b_valid) begin
            slot1 = b_item;
            slot_count = 2'd2;
         end else if (c_valid) begin
            slot1 = c_item;
            slot_count = 2'd2;
         end else begin
            slot_count = 2'd1;
         end
      end else if (b_valid) begin
         slot0 = b_item;
         if (c_valid) begin
            slot1 = c_item;
            slot_count = 2'd2;
         end else begin
            slot_count = 2'd1;
         end
      end else if (c_valid) begin
         slot0 = c_item;
         slot_count = 2'd1;
      end
      slot0.run_last = (slot_count == 2'd1);
      slot1.run_last = (slot_count == 2'd2);
   end

   assign push.count = fire ? slot_count : 2'd0;
   assign push.item0 = slot0;
   assign push.item1 = slot1;

   // Next state; end of text returns to the start of a new text
   always_comb begin
      if (beat.end_of_text) begin
         mode_in   = MODE_IDLE;
         held_in   = '0;
         alive_in  = '0;
         len_in    = '0;
         origin_in = '0;
         line_in   = 24'd1;
         pos_in    = '0;
         star_in   = 1'b0;
      end else begin
         mode_in   = mode_mid;
         held_in   = held_mid;
         alive_in  = alive_mid;
         len_in    = len_mid;
         origin_in = origin_mid;
         line_in   = line_mid;
         pos_in    = pos_ff + 32'd1;
         star_in   = star_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         held_ff   <= '0;
         alive_ff  <= '0;
         len_ff    <= '0;
         origin_ff <= '0;
         line_ff   <= 24'd1;
         pos_ff    <= '0;
         star_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         alive_ff  <= alive_in;
         len_ff    <= len_in;
         origin_ff <= origin_in;
         line_ff   <= line_in;
         pos_ff    <= pos_in;
         star_ff   <= star_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ctok_rsp_fifo.sv
// C source tokenizer: result queue taking up to two tokens a cycle, giving one while the token channel is ready.
// Depends on ctok_pkg and ctok_rsp_if.
`default_nettype none

module ctok_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  ctok_pkg::push_type push,
   output logic               room,
   ctok_rsp_if.source         rsp_bus
);

   ctok_pkg::rsp_item_type entry_ff [ctok_pkg::RSP_DEPTH];
   logic [ctok_pkg::PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ctok_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ctok_pkg::PTR_W-1:0] wr_next;
   logic pop;
   ctok_pkg::rsp_item_type head;

   assign pop     = rsp_bus.valid && rsp_bus.ready;
   assign wr_next = wr_ff + ctok_pkg::PTR_W'(1);

   // Space for two more beats once this cycle's pop is counted
   assign room = count_ff <= (ctok_pkg::CNT_W'(ctok_pkg::RSP_DEPTH - 2) +
                              ctok_pkg::CNT_W'(pop));

   assign wr_in    = wr_ff + ctok_pkg::PTR_W'(push.count);
   assign rd_in    = rd_ff + ctok_pkg::PTR_W'(pop);
   assign count_in = count_ff + ctok_pkg::CNT_W'(push.count) - ctok_pkg::CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
         if (push.count != 2'd0) entry_ff[wr_ff] <= push.item0;
         if (push.count == 2'd2) entry_ff[wr_next] <= push.item1;
      end
   end

   assign head = entry_ff[rd_ff];

   assign rsp_bus.valid          = (count_ff != '0);
   assign rsp_bus.token_kind     = head.token_kind;
   assign rsp_bus.keyword_number = head.keyword_number;
   assign rsp_bus.first_char     = head.first_char;
   assign rsp_bus.second_char    = head.second_char;
   assign rsp_bus.start_offset   = head.start_offset;
   assign rsp_bus.token_length   = head.token_length;
   assign rsp_bus.line_number    = head.line_number;
   assign rsp_bus.run_last       = head.run_last;

endmodule

`default_nettype wire

>>> rtl/core/ctok_checker.sv
// C source tokenizer: port-level checks on the token channel, bound to the top level.
// Depends on ctok_pkg and c_source_tokenizer.
`default_nettype none

module ctok_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  token_kind,
   input logic [4:0]  keyword_number,
   input logic [7:0]  second_char,
   input logic [31:0] start_offset,
   input logic [7:0]  token_length,
   input logic [23:0] line_number,
   input logic        run_last
);

   // Queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token valid right after reset");

   // Stalled token stays and holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_kind) &&
      $stable(start_offset) && $stable(token_length) && $stable(run_last))
      else $error("stalled token changed");

   // Keyword number only on keywords
   a_kw_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind != ctok_pkg::KIND_KEYWORD) |-> keyword_number == 5'd0)
      else $error("keyword number on non-keyword token");

   // Second char only on two-char operators
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (second_char != 8'd0) |->
      (token_kind == ctok_pkg::KIND_OPERATOR) && (token_length == 8'd2))
      else $error("second char on wrong token");

   // Length, line and kind in range
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (token_length != 8'd0) && (line_number != 24'd0) &&
      (token_kind <= ctok_pkg::KIND_UNKNOWN))
      else $error("token field out of range");

endmodule

bind c_source_tokenizer ctok_checker u_ctok_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .token_kind     (rsp_bus.token_kind),
   .keyword_number (rsp_bus.keyword_number),
   .second_char    (rsp_bus.second_char),
   .start_offset   (rsp_bus.start_offset),
   .token_length   (rsp_bus.token_length),
   .line_number    (rsp_bus.line_number),
   .run_last       (rsp_bus.run_last)
);

`default_nettype wire
